// File: design/sfqi_pkg.sv
// Shared types and constants for the sorted frame queue block.
package sfqi_pkg;

  localparam int QUEUE_DEPTH_DEF = 10;
  localparam int SIDE_COUNT_DEF  = 2;
  localparam int SIDE_PORTS      = 2;

  localparam int FRAME_W     = 31;
  localparam int WORD_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_READ_SLOT = 2'd1,
    CMD_READ_LAST = 2'd2
  } cmd_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_EVICTED  = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_READ     = 2'd3
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0]  seed;
    logic [WORD_W-1:0]  inp;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    entry_t            data;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_READ,
    S_EVICT,
    S_SHIFT,
    S_WRITE,
    S_RESP
  } state_t;

endpackage

// File: design/sorted_frame_queue_insert.sv
// Sorted frame queues per side with ordered insert, eviction and read-back.
// The block holds one queue of QUEUE_DEPTH entries per side in a single memory with one read
// port and one write port, kept sorted by frame number; frame 0 marks an empty entry. An
// insert scans the side's queue one slot per cycle through a single compare unit, then, if
// the slot found is occupied, reads the last entry as the evicted one and moves the later
// entries down one slot per cycle before writing the new entry. An insert whose slot is
// empty writes it from S_SCAN; one that finds no later frame or empty slot is dropped. A
// read of a slot inside the queue goes through S_READ, other commands go straight to S_RESP.
// An unused command is taken with no result. After reset the block clears the memory, one
// entry per cycle, all SIDES_USED * QUEUE_DEPTH entries (sides beyond two are not addressable
// and take no storage), and accepts no transaction until it is done. One result at a time is
// held in the output register; s_tready is low while a transaction is being worked on.
module sorted_frame_queue_insert import sfqi_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int SIDE_COUNT  = SIDE_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // frame_number[30:0], packed_input[46:31], seed_word[62:47], read_slot[66:63], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // cmd[1:0], side[2]
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // slot_used[3:0], data_frame[34:4], data_input[50:35], data_seed[66:51], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [OUT_TUSER_W-1:0] m_tuser
);

  localparam int SIDES_USED = (SIDE_COUNT < SIDE_PORTS) ? SIDE_COUNT : SIDE_PORTS;
  localparam int TOTAL      = SIDES_USED * QUEUE_DEPTH;
  localparam int AW         = $clog2(TOTAL);
  localparam int PW         = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0] CLR_LAST  = AW'(TOTAL - 1);

  state_t state, state_next;

  cmd_t              in_cmd;
  logic              in_side;
  entry_t            in_entry;
  logic [SLOT_W-1:0] in_rslot;
  logic              in_side_ok;
  logic              in_rslot_ok;

  logic              side_q;
  logic [FRAME_W-1:0] frame_q;
  entry_t            new_q;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     k;
  logic [AW-1:0]     clr;
  result_t           res;
  result_t           out_res;
  entry_t            last_e [0:SIDE_PORTS-1];

  entry_t            mem [0:TOTAL-1];
  entry_t            rd_data;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;

  logic              hit;
  logic              out_load;

  function automatic logic [AW-1:0] addr_of(input logic sd, input logic [PW-1:0] sl);
    addr_of = AW'(32'(sd) * QUEUE_DEPTH + 32'(sl));
  endfunction

  assign in_cmd         = cmd_t'(s_tuser[1:0]);
  assign in_side        = s_tuser[2];
  assign in_entry.frame = s_tdata[30:0];
  assign in_entry.inp   = s_tdata[46:31];
  assign in_entry.seed  = s_tdata[62:47];
  assign in_rslot       = s_tdata[66:63];
  assign in_side_ok     = 32'(in_side) < 32'(SIDE_COUNT);
  assign in_rslot_ok    = 32'(in_rslot) < 32'(QUEUE_DEPTH);

  assign hit      = (rd_data.frame == '0) || (rd_data.frame > frame_q);
  assign out_load = (state == S_RESP) && (!m_tvalid || m_tready);

  assign m_tdata = {5'b0, out_res.data.seed, out_res.data.inp, out_res.data.frame, out_res.slot};
  assign m_tuser = out_res.status;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == CLR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          case (in_cmd)
            CMD_INSERT:    state_next = in_side_ok ? S_SCAN : S_RESP;
            CMD_READ_SLOT: state_next = (in_side_ok && in_rslot_ok) ? S_READ : S_RESP;
            CMD_READ_LAST: state_next = S_RESP;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = (rd_data.frame == '0) ? S_RESP : S_EVICT;
        end else if (pos == LAST_SLOT) begin
          state_next = S_RESP;
        end
      end
      S_READ:  state_next = S_RESP;
      S_EVICT: state_next = (pos == LAST_SLOT) ? S_WRITE : S_SHIFT;
      S_SHIFT: begin
        if (k - 1'b1 == pos) state_next = S_WRITE;
      end
      S_WRITE: state_next = S_RESP;
      S_RESP: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (in_side_ok) begin
          rd_addr = (in_cmd == CMD_READ_SLOT) ? addr_of(in_side, PW'(in_rslot))
                                              : addr_of(in_side, '0);
        end
      end
      S_SCAN: begin
        if (hit && rd_data.frame == '0) begin
          wr_en   = 1'b1;
          wr_addr = addr_of(side_q, pos);
          wr_data = new_q;
        end else if (hit) begin
          rd_addr = addr_of(side_q, LAST_SLOT);
        end else begin
          rd_addr = addr_of(side_q, pos + 1'b1);
        end
      end
      S_EVICT: begin
        rd_addr = addr_of(side_q, LAST_SLOT - 1'b1);
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(side_q, k);
        wr_data = rd_data;
        rd_addr = addr_of(side_q, k - PW'(2));
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(side_q, pos);
        wr_data = new_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < SIDE_PORTS; i++) last_e[i] <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + 1'b1;
      if (state == S_IDLE && s_tvalid && in_side_ok && in_cmd == CMD_INSERT) begin
        last_e[in_side] <= in_entry;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_res <= res;
    case (state)
      S_IDLE: begin
        side_q  <= in_side;
        frame_q <= in_entry.frame;
        new_q   <= in_entry;
        pos     <= '0;
        if (!in_side_ok) begin
          res <= {(in_cmd == CMD_INSERT) ? ST_DROPPED : ST_READ, SLOT_W'(0), entry_t'('0)};
        end else if (in_cmd == CMD_READ_SLOT) begin
          res <= {ST_READ, in_rslot, entry_t'('0)};
        end else begin
          res <= {ST_READ, SLOT_W'(0), last_e[in_side]};
        end
      end
      S_SCAN: begin
        if (hit) begin
          res <= {ST_INSERTED, SLOT_W'(pos), entry_t'('0)};
        end else if (pos == LAST_SLOT) begin
          res <= {ST_DROPPED, SLOT_W'(0), entry_t'('0)};
        end else begin
          pos <= pos + 1'b1;
        end
      end
      S_READ: begin
        res.data <= rd_data;
      end
      S_EVICT: begin
        k <= LAST_SLOT;
        if (rd_data.frame != '0) res <= {ST_EVICTED, SLOT_W'(pos), rd_data};
      end
      S_SHIFT: begin
        k <= k - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/sfqi_checker.sv
// Port-level checks for the sorted frame queue block, bound to the top level.
module sfqi_checker import sfqi_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic [IN_TUSER_W-1:0]  s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("output valid or input ready right after reset");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[1:0] != CMD_UNUSED |=> !s_tready)
    else $error("input ready while a command is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_DROPPED |-> m_tdata == '0)
    else $error("dropped result carries data");

  a_insert_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_INSERTED |-> m_tdata[66:4] == '0)
    else $error("plain insert result carries evicted data");

endmodule

bind sorted_frame_queue_insert sfqi_checker u_sfqi_checker (.*);
